FILE: rtl/core/cct_pkg.sv
// shared types, constants and decode functions for the character class tokenizer
`timescale 1ns / 1ps

package cct_pkg;

  localparam int POSITION_BITS  = 24;
  localparam int LENGTH_BITS    = 16;
  localparam int CLASS_BITS     = 4;
  localparam int MARK_BITS      = 4;
  localparam int MAX_RESULTS    = 3;
  localparam int COUNT_BITS     = $clog2(MAX_RESULTS + 1);
  localparam int MASK_BITS      = 15;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = MASK_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [MASK_BITS-1:0] RESET_MASK = 15'd2046;
  localparam logic [MARK_BITS-1:0] MARK_LAST  = 4'd14;
  localparam logic [MARK_BITS-1:0] MARK_LEN   = 4'd15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_MASK = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER_EN   = 4'd1;

  localparam logic [CLASS_BITS-1:0] CLASS_SPACE    = 4'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_SEMI     = 4'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_COLON    = 4'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_COMMA    = 4'd3;
  localparam logic [CLASS_BITS-1:0] CLASS_PERIOD   = 4'd4;
  localparam logic [CLASS_BITS-1:0] CLASS_LPAREN   = 4'd5;
  localparam logic [CLASS_BITS-1:0] CLASS_RPAREN   = 4'd6;
  localparam logic [CLASS_BITS-1:0] CLASS_LBRACE   = 4'd7;
  localparam logic [CLASS_BITS-1:0] CLASS_RBRACE   = 4'd8;
  localparam logic [CLASS_BITS-1:0] CLASS_LBRACKET = 4'd9;
  localparam logic [CLASS_BITS-1:0] CLASS_RBRACKET = 4'd10;
  localparam logic [CLASS_BITS-1:0] CLASS_OPERATOR = 4'd11;
  localparam logic [CLASS_BITS-1:0] CLASS_HASH     = 4'd12;
  localparam logic [CLASS_BITS-1:0] CLASS_NAME     = 4'd14;
  localparam logic [CLASS_BITS-1:0] CLASS_NONE     = 4'd15;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;

  typedef struct packed {
    logic [CLASS_BITS-1:0]    token_class;
    logic [POSITION_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0]   token_length;
    logic [POSITION_BITS-1:0] src_line;
    logic                     token_valid;
    logic                     buffer_end;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    logic [COUNT_BITS-1:0]    count;
    result_t [MAX_RESULTS-1:0] res;
  } bundle_t;

  function automatic logic [CLASS_BITS-1:0] classify(input logic [7:0] c);
    logic [CLASS_BITS-1:0] k;
    unique case (c) inside
      [8'h00:8'h20]: k = CLASS_SPACE;
      8'h3B:         k = CLASS_SEMI;
      8'h3A:         k = CLASS_COLON;
      8'h2C:         k = CLASS_COMMA;
      8'h2E:         k = CLASS_PERIOD;
      8'h28:         k = CLASS_LPAREN;
      8'h29:         k = CLASS_RPAREN;
      8'h7B:         k = CLASS_LBRACE;
      8'h7D:         k = CLASS_RBRACE;
      8'h5B:         k = CLASS_LBRACKET;
      8'h5D:         k = CLASS_RBRACKET;
      8'h3D, 8'h3E, 8'h3C, 8'h7C, 8'h26, 8'h2B,
      8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3F, 8'h21:
                     k = CLASS_OPERATOR;
      8'h23:         k = CLASS_HASH;
      default:       k = CLASS_NAME;
    endcase
    return k;
  endfunction

  // expected byte at each place of the line marker
  function automatic logic [7:0] mark_char(input logic [MARK_BITS-1:0] k);
    logic [7:0] m;
    unique case (k)
      4'd0, 4'd1, 4'd14: m = CHAR_UNDERSCORE;
      4'd2:              m = 8'h4F;
      4'd3:              m = 8'h50;
      4'd4, 4'd11:       m = 8'h41;
      4'd5:              m = 8'h4C;
      4'd6:              m = 8'h49;
      4'd7:              m = 8'h4E;
      4'd8:              m = 8'h45;
      4'd9:              m = 8'h53;
      4'd10, 4'd13:      m = 8'h54;
      4'd12:             m = 8'h52;
      default:           m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/cct_front.sv
// front end: configuration registers, byte classification, marker match and token state
`timescale 1ns / 1ps

module cct_front
  import cct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      take,
  input  logic [7:0]                text_byte,
  input  logic                      final_byte,
  output logic                      push,
  output bundle_t                   push_data
);

  typedef struct packed {
    logic [CLASS_BITS-1:0]    cls;
    logic [POSITION_BITS-1:0] ostart;
    logic [LENGTH_BITS-1:0]   olen;
    logic [POSITION_BITS-1:0] oline;
    logic                     oval;
    bundle_t                  b;
  } work_t;

  logic [MASK_BITS-1:0]     single_char_mask;
  logic                     marker_enable;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] current_line, current_line_next;
  logic [CLASS_BITS-1:0]    current_class;
  logic [POSITION_BITS-1:0] open_start;
  logic [LENGTH_BITS-1:0]   open_length;
  logic [POSITION_BITS-1:0] open_line;
  logic                     open_valid;
  logic [MARK_BITS-1:0]     marker_matched, marker_matched_next;
  logic [POSITION_BITS-1:0] marker_start, marker_start_next;
  logic                     reading_digits, reading_digits_next;
  logic                     buffer_stopped, buffer_stopped_next;
  work_t                    work_next;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [LENGTH_BITS-1:0] d);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [POSITION_BITS-1:0] line_step(input logic [POSITION_BITS-1:0] v,
                                                         input logic [3:0] d);
    logic [POSITION_BITS+3:0] s;
    s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{POSITION_BITS{1'b0}}, d};
    return (|s[POSITION_BITS+3:POSITION_BITS]) ? {POSITION_BITS{1'b1}}
                                               : s[POSITION_BITS-1:0];
  endfunction

  function automatic work_t emit(input work_t w, input logic [CLASS_BITS-1:0] cls,
                                 input logic [POSITION_BITS-1:0] start,
                                 input logic [LENGTH_BITS-1:0] len,
                                 input logic [POSITION_BITS-1:0] line,
                                 input logic valid, input logic last);
    work_t r;
    r = w;
    if (r.b.count < COUNT_BITS'(MAX_RESULTS)) begin
      r.b.res[r.b.count] = '{token_class: cls, start_offset: start, token_length: len,
                             src_line: line, token_valid: valid, buffer_end: last};
      r.b.count = r.b.count + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t close_open(input work_t w);
    work_t r;
    r = w;
    if (r.oval) r = emit(r, r.cls, r.ostart, r.olen, r.oline, 1'b1, 1'b0);
    r.oval = 1'b0;
    return r;
  endfunction

  function automatic work_t open_token(input work_t w, input logic [CLASS_BITS-1:0] cls,
                                       input logic [POSITION_BITS-1:0] start,
                                       input logic [LENGTH_BITS-1:0] len,
                                       input logic [POSITION_BITS-1:0] line);
    work_t r;
    r = close_open(w);
    r.oval   = 1'b1;
    r.ostart = start;
    r.olen   = len;
    r.oline  = line;
    r.cls    = cls;
    return r;
  endfunction

  function automatic logic is_single(input logic [CLASS_BITS-1:0] cls,
                                     input logic [MASK_BITS-1:0] mask);
    return (cls != CLASS_NONE) && mask[cls];
  endfunction

  function automatic work_t feed_char(input work_t w, input logic [POSITION_BITS-1:0] pos,
                                      input logic [CLASS_BITS-1:0] cls,
                                      input logic [POSITION_BITS-1:0] line,
                                      input logic [MASK_BITS-1:0] mask);
    work_t r;
    r = w;
    if (cls == CLASS_SPACE) begin
      r = close_open(r);
      r.cls = CLASS_SPACE;
    end else if (r.oval && cls == r.cls && !is_single(cls, mask)) begin
      r.olen = len_add(r.olen, LENGTH_BITS'(1));
    end else begin
      r = open_token(r, cls, pos, LENGTH_BITS'(1), line);
    end
    return r;
  endfunction

  // replay of held marker bytes as one name run
  function automatic work_t feed_run(input work_t w, input logic [POSITION_BITS-1:0] start,
                                     input logic [MARK_BITS-1:0] cnt,
                                     input logic [POSITION_BITS-1:0] line,
                                     input logic [MASK_BITS-1:0] mask);
    work_t r;
    r = w;
    if (r.oval && r.cls == CLASS_NAME && !is_single(CLASS_NAME, mask))
      r.olen = len_add(r.olen, LENGTH_BITS'(cnt));
    else
      r = open_token(r, CLASS_NAME, start, LENGTH_BITS'(cnt), line);
    return r;
  endfunction

  always_comb begin
    work_t                    w;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] line;
    logic [MARK_BITS-1:0]     mm;
    logic [POSITION_BITS-1:0] ms;
    logic                     rd;
    logic                     stop;
    logic [CLASS_BITS-1:0]    cls;
    logic                     fin;

    w.cls    = current_class;
    w.ostart = open_start;
    w.olen   = open_length;
    w.oline  = open_line;
    w.oval   = open_valid;
    w.b      = '0;
    pos      = byte_position;
    line     = current_line;
    mm       = marker_matched;
    ms       = marker_start;
    rd       = reading_digits;
    stop     = buffer_stopped;
    cls      = classify(text_byte);
    fin      = 1'b0;

    if (!buffer_stopped) begin
      if (text_byte == 8'h00) begin
        fin = 1'b1;
      end else begin
        if (rd) begin
          if (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE) begin
            line = line_step(line, text_byte[3:0]);
          end else begin
            rd = 1'b0;
            w  = feed_char(w, pos, cls, line, single_char_mask);
          end
        end else if (mm == '0) begin
          if (marker_enable && text_byte == CHAR_UNDERSCORE) begin
            mm = MARK_BITS'(1);
            ms = pos;
          end else begin
            w = feed_char(w, pos, cls, line, single_char_mask);
          end
        end else if (mm < MARK_LEN && text_byte == mark_char(mm)) begin
          if (mm == MARK_LAST) begin
            mm   = '0;
            rd   = 1'b1;
            line = '0;
          end else begin
            mm = mm + 1'b1;
          end
        end else if (text_byte == CHAR_UNDERSCORE && mm == MARK_BITS'(2)) begin
          w  = feed_run(w, ms, MARK_BITS'(1), line, single_char_mask);
          ms = pos_inc(ms);
        end else if (text_byte == CHAR_UNDERSCORE && mm >= MARK_BITS'(3)) begin
          w  = feed_run(w, ms, mm, line, single_char_mask);
          mm = MARK_BITS'(1);
          ms = pos;
        end else begin
          w  = feed_run(w, ms, mm, line, single_char_mask);
          mm = '0;
          w  = feed_char(w, pos, cls, line, single_char_mask);
        end
        pos = pos_inc(pos);
        fin = final_byte;
      end

      if (fin) begin
        if (mm != '0) w = feed_run(w, ms, mm, line, single_char_mask);
        mm = '0;
        rd = 1'b0;
        if (w.oval) w = emit(w, w.cls, w.ostart, w.olen, w.oline, 1'b1, 1'b1);
        else        w = emit(w, CLASS_SPACE, pos, '0, line, 1'b0, 1'b1);
        w.oval = 1'b0;
        w.cls  = CLASS_NONE;
        stop   = 1'b1;
      end
    end

    work_next           = w;
    byte_position_next  = pos;
    current_line_next   = line;
    marker_matched_next = mm;
    marker_start_next   = ms;
    reading_digits_next = rd;
    buffer_stopped_next = stop;
  end

  assign push      = take && (work_next.b.count != '0);
  assign push_data = work_next.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_char_mask <= RESET_MASK;
      marker_enable    <= 1'b1;
      byte_position    <= '0;
      current_line     <= '0;
      current_class    <= CLASS_NONE;
      open_start       <= '0;
      open_length      <= '0;
      open_line        <= '0;
      open_valid       <= 1'b0;
      marker_matched   <= '0;
      marker_start     <= '0;
      reading_digits   <= 1'b0;
      buffer_stopped   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_SINGLE_MASK) single_char_mask <= cfg_data;
      if (cfg_we && cfg_index == REG_MARKER_EN)   marker_enable    <= cfg_data[0];
      if (take) begin
        byte_position  <= byte_position_next;
        current_line   <= current_line_next;
        current_class  <= work_next.cls;
        open_start     <= work_next.ostart;
        open_length    <= work_next.olen;
        open_line      <= work_next.oline;
        open_valid     <= work_next.oval;
        marker_matched <= marker_matched_next;
        marker_start   <= marker_start_next;
        reading_digits <= reading_digits_next;
        buffer_stopped <= buffer_stopped_next;
      end
    end
  end

endmodule

FILE: rtl/core/cct_queue.sv
// short queue of result bundles between front and back end
`timescale 1ns / 1ps

module cct_queue
  import cct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  bundle_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;

  assign head  = slots[rd_ptr];
  assign full  = (fill == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: rtl/core/cct_emit.sv
// back end: unpacks queued bundles into single result requests
`timescale 1ns / 1ps

module cct_emit
  import cct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  bundle_t                   head,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CLASS_BITS-1:0]     token_class,
  output logic [POSITION_BITS-1:0]  start_offset,
  output logic [LENGTH_BITS-1:0]    token_length,
  output logic [POSITION_BITS-1:0]  src_line,
  output logic                      token_valid,
  output logic                      buffer_end
);

  bundle_t               cur;
  logic                  cur_valid;
  logic [COUNT_BITS-1:0] idx;
  logic                  done;
  logic                  last;
  logic                  need;
  result_t               sel;

  assign done = cur_valid && !out_stall;
  assign last = (idx == cur.count - 1'b1);
  assign need = !cur_valid || (done && last);
  assign pop  = need && !q_empty;
  assign sel  = cur.res[idx];

  assign out_valid    = cur_valid;
  assign token_class  = sel.token_class;
  assign start_offset = sel.start_offset;
  assign token_length = sel.token_length;
  assign src_line     = sel.src_line;
  assign token_valid  = sel.token_valid;
  assign buffer_end   = sel.buffer_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (need) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (done) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

endmodule

FILE: rtl/core/char_class_tokenizer.sv
// top level of the character class tokenizer
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   text_byte, final_byte
//   out      output     out_valid / out_stall token_class, start_offset, token_length,
//                                             src_line, token_valid, buffer_end
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle is accepted while in_stall is low; the front end decides all results of a byte in that cycle
// a byte causing n results gives n output requests, one request each
// a four-deep bundle queue absorbs output stalls; in_stall rises only when it is full
// reset needs no clearing pass; mask resets to 2046, marker enable to 1
`timescale 1ns / 1ps

module char_class_tokenizer
  import cct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                text_byte,
  input  logic                      final_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CLASS_BITS-1:0]     token_class,
  output logic [POSITION_BITS-1:0]  start_offset,
  output logic [LENGTH_BITS-1:0]    token_length,
  output logic [POSITION_BITS-1:0]  src_line,
  output logic                      token_valid,
  output logic                      buffer_end
);

  logic    take;
  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;
  logic    q_full;
  logic    q_empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !in_stall;

  cct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .push       (push),
    .push_data  (push_data)
  );

  cct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  cct_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_class  (token_class),
    .start_offset (start_offset),
    .token_length (token_length),
    .src_line     (src_line),
    .token_valid  (token_valid),
    .buffer_end   (buffer_end)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("bundle pushed into full queue");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && buffer_end) |=> !out_valid)
    else $error("request after end of buffer");

  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !token_valid) |-> (buffer_end && token_length == '0))
    else $error("tokenless request not at end of buffer");

  a_real_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_valid) |-> (token_length != '0 && token_class != CLASS_NONE))
    else $error("token request with empty length or no class");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the character class tokenizer
`timescale 1ns / 1ps

module tb;
  import cct_pkg::*;

  localparam longint POS_MAX = (longint'(1) << POSITION_BITS) - 1;
  localparam longint LEN_MAX = (longint'(1) << LENGTH_BITS) - 1;
  localparam int DEAD_LIMIT = 1000;
  localparam int PAUSE = 8;

  typedef struct {
    bit [7:0] b;
    bit       typed;
    result_t  want;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               text_byte = 8'h00;
  logic                     final_byte = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CLASS_BITS-1:0]    token_class;
  logic [POSITION_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0]   token_length;
  logic [POSITION_BITS-1:0] src_line;
  logic                     token_valid;
  logic                     buffer_end;

  char_class_tokenizer dut (.*);

  always #4 clk = ~clk;

  // tokenizer model state
  bit [MASK_BITS-1:0]     mask_r = RESET_MASK;
  bit                     mark_en_r = 1'b1;
  bit [POSITION_BITS-1:0] pos_q = '0;
  bit [POSITION_BITS-1:0] line_q = '0;
  bit [CLASS_BITS-1:0]    cur_cls = CLASS_NONE;
  bit [POSITION_BITS-1:0] tok_start = '0;
  bit [LENGTH_BITS-1:0]   tok_len = '0;
  bit [POSITION_BITS-1:0] tok_line = '0;
  bit                     tok_open = 1'b0;
  bit [MARK_BITS-1:0]     mk_cnt = '0;
  bit [POSITION_BITS-1:0] mk_start = '0;
  bit                     in_digits = 1'b0;
  bit                     stopped = 1'b0;

  bit [7:0] line_tag [15] = '{8'h5F, 8'h5F, 8'h4F, 8'h50, 8'h41, 8'h4C, 8'h49, 8'h4E,
                              8'h45, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h5F};
  string    punct = ";:,.(){}[]=><|&+-*/%?!#";

  result_t  fresh_q[$];
  result_t  want_q[$];
  row_t     script[$];
  bit       use_typed = 1'b0;
  result_t  typed_tok;
  bit       no_gaps = 1'b0;
  int       errors = 0;
  int       dead_cycles = 0;

  function automatic bit [CLASS_BITS-1:0] cls_of(input bit [7:0] c);
    if (c <= 8'h20) return CLASS_SPACE;
    case (c)
      ";": return CLASS_SEMI;
      ":": return CLASS_COLON;
      ",": return CLASS_COMMA;
      ".": return CLASS_PERIOD;
      "(": return CLASS_LPAREN;
      ")": return CLASS_RPAREN;
      "{": return CLASS_LBRACE;
      "}": return CLASS_RBRACE;
      "[": return CLASS_LBRACKET;
      "]": return CLASS_RBRACKET;
      "=", ">", "<", "|", "&", "+", "-", "*", "/", "%", "?", "!": return CLASS_OPERATOR;
      "#": return CLASS_HASH;
      default: return CLASS_NAME;
    endcase
  endfunction

  function automatic bit is_single(input bit [CLASS_BITS-1:0] cls);
    return cls != CLASS_NONE && mask_r[cls];
  endfunction

  function automatic bit [LENGTH_BITS-1:0] sat_len(input longint v);
    return (v > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0] : v[LENGTH_BITS-1:0];
  endfunction

  function automatic void post_token(input bit [CLASS_BITS-1:0] cls,
                                     input bit [POSITION_BITS-1:0] start,
                                     input bit [LENGTH_BITS-1:0] len,
                                     input bit [POSITION_BITS-1:0] ln,
                                     input bit tv, input bit be);
    result_t r;
    r.token_class  = cls;
    r.start_offset = start;
    r.token_length = len;
    r.src_line     = ln;
    r.token_valid  = tv;
    r.buffer_end   = be;
    fresh_q.push_back(r);
  endfunction

  function automatic void close_tok();
    if (tok_open) post_token(cur_cls, tok_start, tok_len, tok_line, 1'b1, 1'b0);
    tok_open = 1'b0;
  endfunction

  function automatic void open_tok(input bit [CLASS_BITS-1:0] cls,
                                   input bit [POSITION_BITS-1:0] start, input longint len);
    close_tok();
    tok_open  = 1'b1;
    tok_start = start;
    tok_len   = sat_len(len);
    tok_line  = line_q;
    cur_cls   = cls;
  endfunction

  function automatic void feed_char(input bit [POSITION_BITS-1:0] p,
                                    input bit [CLASS_BITS-1:0] cls);
    if (cls == CLASS_SPACE) begin
      close_tok();
      cur_cls = CLASS_SPACE;
    end else if (tok_open && cls == cur_cls && !is_single(cls)) begin
      tok_len = sat_len(longint'(tok_len) + 1);
    end else begin
      open_tok(cls, p, 1);
    end
  endfunction

  // held tag bytes come back as one name run
  function automatic void feed_run(input bit [POSITION_BITS-1:0] start, input longint count);
    if (tok_open && cur_cls == CLASS_NAME && !is_single(CLASS_NAME))
      tok_len = sat_len(longint'(tok_len) + count);
    else
      open_tok(CLASS_NAME, start, count);
  endfunction

  function automatic void end_buffer();
    if (mk_cnt != 0) feed_run(mk_start, longint'(mk_cnt));
    mk_cnt = '0;
    in_digits = 1'b0;
    if (tok_open) post_token(cur_cls, tok_start, tok_len, tok_line, 1'b1, 1'b1);
    else post_token(CLASS_SPACE, pos_q, '0, line_q, 1'b0, 1'b1);
    tok_open = 1'b0;
    cur_cls = CLASS_NONE;
    stopped = 1'b1;
  endfunction

  function automatic void step_char(input bit [7:0] c);
    longint v;
    if (in_digits) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        v = longint'(line_q) * 10 + longint'(c - CHAR_ZERO);
        line_q = (v > POS_MAX) ? POS_MAX[POSITION_BITS-1:0] : v[POSITION_BITS-1:0];
        return;
      end
      in_digits = 1'b0;
      feed_char(pos_q, cls_of(c));
      return;
    end
    if (mk_cnt == 0) begin
      if (mark_en_r && c == CHAR_UNDERSCORE) begin
        mk_cnt = MARK_BITS'(1);
        mk_start = pos_q;
      end else begin
        feed_char(pos_q, cls_of(c));
      end
      return;
    end
    if (c == line_tag[mk_cnt]) begin
      if (mk_cnt == MARK_LAST) begin
        mk_cnt = '0;
        in_digits = 1'b1;
        line_q = '0;
      end else begin
        mk_cnt = mk_cnt + 1'b1;
      end
      return;
    end
    if (c == CHAR_UNDERSCORE && mk_cnt == 2) begin
      feed_run(mk_start, 1);
      mk_start = (longint'(mk_start) == POS_MAX) ? mk_start : mk_start + 1'b1;
    end else if (c == CHAR_UNDERSCORE && mk_cnt >= 3) begin
      feed_run(mk_start, longint'(mk_cnt));
      mk_cnt = MARK_BITS'(1);
      mk_start = pos_q;
    end else begin
      feed_run(mk_start, longint'(mk_cnt));
      mk_cnt = '0;
      feed_char(pos_q, cls_of(c));
    end
  endfunction

  function automatic void lex_byte(input bit [7:0] c, input bit fin);
    if (stopped) return;
    if (c == 8'h00) begin
      end_buffer();
      return;
    end
    step_char(c);
    if (longint'(pos_q) != POS_MAX) pos_q = pos_q + 1'b1;
    if (fin) end_buffer();
  endfunction

  function automatic bit take_break();
    return !no_gaps && ($urandom_range(0, 99) < 13);
  endfunction

  function automatic void add_row(input bit [7:0] b, input bit typed = 1'b0,
                                  input bit [CLASS_BITS-1:0] cls = CLASS_SPACE,
                                  input int start = 0, input int len = 0);
    row_t r;
    r.b = b;
    r.typed = typed;
    r.want.token_class  = cls;
    r.want.start_offset = POSITION_BITS'(start);
    r.want.token_length = LENGTH_BITS'(len);
    r.want.src_line     = '0;
    r.want.token_valid  = 1'b1;
    r.want.buffer_end   = 1'b0;
    script.push_back(r);
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit fin);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    lex_byte(b, fin);
    if (use_typed) want_q.push_back(typed_tok);
    else foreach (fresh_q[i]) want_q.push_back(fresh_q[i]);
    fresh_q.delete();
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SINGLE_MASK) mask_r = val;
    else if (idx == REG_MARKER_EN) mark_en_r = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tag(input int from, input int upto);
    for (int i = from; i < upto; i++) send_byte(line_tag[i], 1'b0);
  endtask

  // mostly tokens and line tags, some broken tags and noise
  task automatic gen_burst(input int n);
    int sent;
    int len;
    bit [7:0] c;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1)) c = punct[$urandom_range(0, punct.len() - 1)];
          else c = 8'($urandom_range(33, 255));
          len = $urandom_range(1, 5);
          repeat (len) send_byte(c, 1'b0);
        end
        3: begin
          len = $urandom_range(1, 3);
          repeat (len) send_byte(8'($urandom_range(1, 32)), 1'b0);
        end
        4, 5: begin
          send_tag(0, 15);
          len = $urandom_range(0, 9);
          repeat (len) send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
          len += 15;
        end
        6: begin
          len = $urandom_range(1, 14);
          send_tag(0, len);
          if ($urandom_range(0, 1)) send_byte(CHAR_UNDERSCORE, 1'b0);
          else send_byte(8'($urandom_range(1, 255)), 1'b0);
          len += 1;
        end
        7: begin
          len = $urandom_range(1, 4);
          repeat (len) send_byte(CHAR_UNDERSCORE, 1'b0);
        end
        default: begin
          len = 1;
          send_byte(8'($urandom_range(1, 255)), 1'b0);
        end
      endcase
      sent += len;
    end
  endtask

  function automatic void check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  always @(negedge clk) out_stall <= take_break();

  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t ns: token with none expected, got class %0d offset %0d length %0d",
                 $time, token_class, start_offset, token_length);
      end else begin
        w = want_q.pop_front();
        check_field("token_class", longint'(w.token_class), longint'(token_class));
        check_field("start_offset", longint'(w.start_offset), longint'(start_offset));
        check_field("token_length", longint'(w.token_length), longint'(token_length));
        check_field("src_line", longint'(w.src_line), longint'(src_line));
        check_field("token_valid", longint'(w.token_valid), longint'(token_valid));
        check_field("buffer_end", longint'(w.buffer_end), longint'(buffer_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      dead_cycles <= 0;
    else if (dead_cycles >= DEAD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      dead_cycles <= dead_cycles + 1;
  end

  initial begin
    int k;
    add_row("a");
    add_row("b");
    add_row(8'h20, 1'b1, CLASS_NAME, 0, 2);
    add_row(";");
    add_row(";", 1'b1, CLASS_SEMI, 3, 1);
    add_row(8'h21, 1'b1, CLASS_SEMI, 4, 1);
    add_row("=");
    add_row(8'hFF, 1'b1, CLASS_OPERATOR, 5, 2);
    add_row(8'h80);
    add_row(8'h20, 1'b1, CLASS_NAME, 7, 2);
    add_row(8'h01);
    add_row("(");
    add_row(")");
    add_row("{");
    add_row("}");
    add_row("[");
    add_row("]");
    add_row(".");
    add_row(",");
    add_row(":");
    add_row("#");
    add_row("#");
    add_row(8'h20, 1'b1, CLASS_HASH, 20, 2);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      use_typed = script[i].typed;
      typed_tok = script[i].want;
      send_byte(script[i].b, 1'b0);
      use_typed = 1'b0;
    end

    settle();
    write_reg(REG_SINGLE_MASK, '0);
    gen_burst(30);

    // tag split across a marker enable change, digits saturate the line
    send_byte(8'h20, 1'b0);
    send_tag(0, 6);
    settle();
    write_reg(REG_MARKER_EN, CFG_DATA_BITS'(0));
    send_tag(6, 15);
    repeat (8) send_byte("9", 1'b0);
    send_byte("x", 1'b0);
    send_byte(8'h20, 1'b0);
    gen_burst(25);

    settle();
    write_reg(REG_SINGLE_MASK, 15'h7FFF);
    write_reg(REG_MARKER_EN, CFG_DATA_BITS'(1));
    gen_burst(30);

    settle();
    no_gaps = 1'b1;
    write_reg(REG_SINGLE_MASK, CFG_DATA_BITS'($urandom_range(0, 32767)));
    write_reg(REG_MARKER_EN, CFG_DATA_BITS'($urandom_range(0, 1)));
    gen_burst(30);

    settle();
    no_gaps = 1'b0;
    write_reg(REG_SINGLE_MASK, RESET_MASK);
    write_reg(REG_MARKER_EN, CFG_DATA_BITS'(1));
    gen_burst(20);

    case ($urandom_range(0, 2))
      0: begin
        k = $urandom_range(1, 14);
        send_tag(0, k);
      end
      1: begin
        send_tag(0, 15);
        k = $urandom_range(1, 4);
        repeat (k) send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
      end
      default: send_byte(8'h20, 1'b0);
    endcase
    if ($urandom_range(0, 1)) send_byte(8'h00, 1'($urandom_range(0, 1)));
    else send_byte(8'($urandom_range(1, 255)), 1'b1);
    // bytes after the end of the buffer give nothing
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    settle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: char_class_tokenizer.f
rtl/core/cct_pkg.sv
rtl/core/cct_front.sv
rtl/core/cct_queue.sv
rtl/core/cct_emit.sv
rtl/core/char_class_tokenizer.sv
tb/tb.sv
